[rtl/aes128_pkg.sv]
// AES-128 package: payload types, S-box tables, round functions and round constants.
// Used by the cipher top level and its port checker; depends on nothing.
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 64;

	localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
	localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

	localparam logic CmdEncrypt = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] out_high;
		logic [63:0] out_low;
	} aes_out_t;

	localparam logic [7:0] FwdBox [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] InvBox [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	localparam logic [7:0] Rcon [NumRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// One column through the forward or inverse column mix.
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m [4];
		logic [31:0] r;
		for (int k = 0; k < 4; k++) begin
			a[k]  = c[31-8*k -: 8];
			a2[k] = xtime(a[k]);
			a4[k] = xtime(a2[k]);
			a8[k] = xtime(a4[k]);
		end
		for (int rr = 0; rr < 4; rr++) begin
			if (inv) begin
				// 0e, 0b, 0d, 09 rotated by row
				m[rr] = (a8[rr] ^ a4[rr] ^ a2[rr])
				      ^ (a8[(rr+1)%4] ^ a2[(rr+1)%4] ^ a[(rr+1)%4])
				      ^ (a8[(rr+2)%4] ^ a4[(rr+2)%4] ^ a[(rr+2)%4])
				      ^ (a8[(rr+3)%4] ^ a[(rr+3)%4]);
			end else begin
				m[rr] = a2[rr] ^ (a2[(rr+1)%4] ^ a[(rr+1)%4]) ^ a[(rr+2)%4] ^ a[(rr+3)%4];
			end
		end
		r = {m[0], m[1], m[2], m[3]};
		return r;
	endfunction

	function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
		logic [127:0] r;
		for (int c = 0; c < 4; c++) r[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
		return r;
	endfunction

	// Byte substitution followed by the row shift; byte index = column * 4 + row.
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [7:0] t [16];
		logic [127:0] r;
		for (int i = 0; i < 16; i++) t[i] = inv ? InvBox[s[127-8*i -: 8]] : FwdBox[s[127-8*i -: 8]];
		for (int c = 0; c < 4; c++) begin
			for (int rr = 0; rr < 4; rr++) begin
				r[127-8*(c*4+rr) -: 8] = inv ? t[((c+4-rr)%4)*4+rr] : t[((c+rr)%4)*4+rr];
			end
		end
		return r;
	endfunction

	// Next round key from the previous one.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w [4];
		logic [31:0] t;
		logic [127:0] r;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		t = {FwdBox[w[3][23:16]] ^ rc, FwdBox[w[3][15:8]], FwdBox[w[3][7:0]], FwdBox[w[3][31:24]]};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		r = {w[0], w[1], w[2], w[3]};
		return r;
	endfunction

endpackage

[rtl/aes128_block_cipher.sv]
// AES-128 cipher, one block per cycle unless the result is stalled: ten pipelined
// rounds plus an output register. Depends on aes128_pkg.
//
// Takes one block every cycle while the result is not stalled and passes it
// through an input stage for the first key add, one stage per round (S-box,
// row shift, column mix except in the last round, and key add) and a result
// register. The whole pipeline holds as one while the result is stalled. The
// round keys are expanded from the key registers one round per cycle and kept
// in registers, which settle after a key write (and after reset while the clock
// runs); write the key only while no block is in flight.
module aes128_block_cipher
	import aes128_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  aes_in_t             in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output aes_out_t            out_data
);

	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] rk_enc_q [NumRounds+1];
	logic [127:0] rk_dec_q [NumRounds+1];

	// hold key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegKeyHigh: key_high_q <= cfg_data;
				RegKeyLow:  key_low_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// expand round keys one round per cycle; the chain settles between key writes
	always_ff @(posedge clk) begin
		rk_enc_q[0] <= {key_high_q, key_low_q};
		for (int r = 1; r <= NumRounds; r++) rk_enc_q[r] <= next_key(rk_enc_q[r-1], Rcon[r-1]);
		for (int r = 0; r <= NumRounds; r++) begin
			rk_dec_q[r] <= (r == 0 || r == NumRounds) ? rk_enc_q[r] : mix_all(rk_enc_q[r], 1'b1);
		end
	end

	// round stages
	logic                 adv;
	logic                 v_s   [NumRounds+1];
	logic                 dec_s [NumRounds+1];
	logic [127:0]         st_s  [NumRounds+1];
	logic [127:0]         rnd   [NumRounds];
	aes_out_t             res_q;
	logic                 res_valid_q;

	assign adv      = !res_valid_q || !out_stall;
	assign in_stall = !adv;

	always_comb begin
		for (int r = 1; r <= NumRounds; r++) begin
			logic [127:0] t;
			t = sub_shift(st_s[r-1], dec_s[r-1]);
			if (r < NumRounds) t = mix_all(t, dec_s[r-1]);
			rnd[r-1] = t ^ (dec_s[r-1] ? rk_dec_q[NumRounds-r] : rk_enc_q[r]);
		end
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r <= NumRounds; r++) v_s[r] <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int r = 1; r <= NumRounds; r++) v_s[r] <= v_s[r-1];
			res_valid_q <= v_s[NumRounds];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s[0] <= in_data.cmd;
			st_s[0]  <= {in_data.data_high, in_data.data_low}
			          ^ ((in_data.cmd == CmdDecrypt) ? rk_enc_q[NumRounds] : rk_enc_q[0]);
			for (int r = 1; r <= NumRounds; r++) begin
				dec_s[r] <= dec_s[r-1];
				st_s[r]  <= rnd[r-1];
			end
			res_q <= st_s[NumRounds];
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

[rtl/aes128_chk.sv]
// Port checker for the AES-128 cipher, bound to the top level.
// Depends on aes128_pkg and aes128_block_cipher.
module aes128_chk
	import aes128_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input aes_out_t out_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// input stalls only behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// no stall while the output is free
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

endmodule

bind aes128_block_cipher aes128_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[test/aes128_cipher_checker.sv]
// Transfer checker for the AES-128 cipher: watches both channels and the key port,
// predicts each result with its own AES model and compares. Depends on aes128_pkg.
`timescale 1ns / 100ps

module aes128_cipher_checker
	import aes128_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  aes_in_t             in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  aes_out_t            out_data,
	output int                  fail_count,
	output int                  pending
);

	logic [63:0] key_hi;
	logic [63:0] key_lo;
	aes_out_t    block_queue [$];
	logic [7:0]  sbox [256];
	logic [7:0]  sbox_inv [256];

	assign pending = block_queue.size();

	// Build both substitution tables from the field inverse and the affine map.
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

	initial begin
		logic [7:0] inv, v;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
			v = 8'h63;
			for (int i = 0; i < 8; i++)
				v[i] = v[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8]
				     ^ inv[(i+7)%8];
			sbox[x] = v;
			sbox_inv[v] = x[7:0];
		end
	end

	function automatic void mix_state(ref logic [7:0] s [16], input logic dec);
		logic [7:0] a [4];
		logic [7:0] coef [4];
		logic [7:0] v;
		if (dec) begin
			coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		end else begin
			coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		end
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) v ^= gmul(coef[(k-r+4)%4], a[k]);
				s[c*4+r] = v;
			end
		end
	endfunction

	// Compute one cipher or inverse-cipher result under the current key.
	function automatic aes_out_t cipher_block(input aes_in_t item);
		logic [7:0] w [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] rk [16];
		logic [7:0] tw [4];
		logic [7:0] tmp, rc;
		logic [127:0] kb, db;
		logic dec;
		int kr;
		aes_out_t res;
		dec = item.cmd;
		kb = {key_hi, key_lo};
		db = {item.data_high, item.data_low};
		for (int i = 0; i < 16; i++) begin
			w[i] = kb[127-8*i -: 8];
			s[i] = db[127-8*i -: 8];
		end
		rc = 8'h01;
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) tw[j] = w[i-4+j];
			if (i % 16 == 0) begin
				tmp = tw[0]; tw[0] = tw[1]; tw[1] = tw[2]; tw[2] = tw[3]; tw[3] = tmp;
				for (int j = 0; j < 4; j++) tw[j] = sbox[tw[j]];
				tw[0] ^= rc;
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end
			for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ tw[j];
		end
		for (int i = 0; i < 16; i++) s[i] ^= w[(dec ? 160 : 0) + i];
		for (int round = 1; round <= NumRounds; round++) begin
			kr = dec ? NumRounds - round : round;
			for (int i = 0; i < 16; i++) t[i] = dec ? sbox_inv[s[i]] : sbox[s[i]];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[c*4+r] = dec ? t[((c+4-r)%4)*4+r] : t[((c+r)%4)*4+r];
			for (int i = 0; i < 16; i++) rk[i] = w[kr*16+i];
			if (round < NumRounds) begin
				mix_state(s, dec);
				if (dec) mix_state(rk, 1'b1);
			end
			for (int i = 0; i < 16; i++) s[i] ^= rk[i];
		end
		for (int i = 0; i < 16; i++) db[127-8*i -: 8] = s[i];
		res.out_high = db[127:64];
		res.out_low = db[63:0];
		return res;
	endfunction

	// Track the key, predict on each input transfer, compare on each output transfer.
	always @(posedge clk or negedge arst_n) begin
		aes_out_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			key_hi <= '0;
			key_lo <= '0;
			fail_count <= 0;
			block_queue.delete();
		end else begin
			if (in_valid && !in_stall) block_queue.push_back(cipher_block(in_data));
			if (out_valid && !out_stall) begin
				if (block_queue.size() == 0) begin
					$error("result transfer with nothing expected: %h", out_data);
					errs++;
				end else begin
					want = block_queue.pop_front();
					if (want.out_high !== out_data.out_high) begin
						$error("out_high expected %h actual %h", want.out_high,
							out_data.out_high);
						errs++;
					end
					if (want.out_low !== out_data.out_low) begin
						$error("out_low expected %h actual %h", want.out_low,
							out_data.out_low);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (cfg_we) begin
				if (cfg_idx == RegKeyHigh) key_hi <= cfg_data;
				else if (cfg_idx == RegKeyLow) key_lo <= cfg_data;
			end
		end
	end

endmodule

[test/tb_top.sv]
// Top of the AES-128 cipher testbench: clock, reset, key writes, block stimulus
// and verdict. Depends on aes128_pkg, aes128_block_cipher and aes128_cipher_checker.
`timescale 1ns / 100ps

module tb_top;
	import aes128_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	aes_in_t             in_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	aes_out_t            out_data;
	int                  fail_count;
	int                  pending;
	logic                calm;
	logic                hold_off;
	logic                long_done = 1'b0;

	aes128_block_cipher dut (.*);
	aes128_cipher_checker checker_i (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Receiver stalls in random bursts; one long hold-off; none at the end.
	always @(posedge clk) begin
		int n;
		if (hold_off && !long_done) begin
			long_done <= 1'b1;
			out_stall <= 1'b1;
			repeat (60) @(posedge clk);
			out_stall <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 10);
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one block and hold it until transferred, with an optional random gap first.
	task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{cmd: cmd, data_high: hi, data_low: lo};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_blocks();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Data word biased toward all-zero and all-one halves.
	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	initial begin
		logic [63:0] keys [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = RegKeyHigh;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (14) @(posedge clk);

		// Directed: all-zero key before any write, then standard vectors.
		send_block(CmdEncrypt, '0, '0);
		send_block(CmdDecrypt, '0, '0);
		send_block(CmdEncrypt, '1, '1);
		send_block(CmdDecrypt, '1, '1);
		drain_blocks();
		write_key(RegKeyHigh, 64'h0001020304050607);
		write_key(RegKeyLow, 64'h08090a0b0c0d0e0f);
		repeat (15) @(posedge clk);
		send_block(CmdEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(CmdDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(CmdEncrypt, '1, '0);
		send_block(CmdDecrypt, '0, '1);
		drain_blocks();
		write_key(RegKeyHigh, '1);
		write_key(RegKeyLow, '1);
		repeat (15) @(posedge clk);
		for (int i = 0; i < 8; i++) send_block(i[0], pick64(), pick64());

		// Random phases with several keys, extremes among them.
		keys = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000001, 64'h0};
		for (int ph = 0; ph < 6; ph++) begin
			drain_blocks();
			write_key(RegKeyHigh, ph < 2 ? keys[ph] : rand64());
			write_key(RegKeyLow, ph < 2 ? keys[ph ^ 1] : rand64());
			repeat (15) @(posedge clk);
			if (ph == 2) hold_off <= 1'b1;
			if (ph == 5) calm = 1'b1;
			for (int i = 0; i < 225; i++)
				send_block(1'($urandom_range(0, 1)), pick64(), pick64());
		end
		drain_blocks();

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
